// ===== hdl/mecq_pkg.sv =====
`default_nettype none
package mecq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = 4;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;

  localparam logic [1:0] MODE_REPORT = 2'd0;
  localparam logic [1:0] MODE_FLUSH  = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;

  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;

  localparam logic [2:0] BTN_NONE        = 3'd0;
  localparam logic [2:0] BTN_LEFT        = 3'd1;
  localparam logic [2:0] BTN_RIGHT       = 3'd2;
  localparam logic [2:0] BTN_MIDDLE      = 3'd3;
  localparam logic [2:0] BTN_SCROLL_UP   = 3'd4;
  localparam logic [2:0] BTN_SCROLL_DOWN = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         button;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } entry_t;

  typedef enum logic [1:0] {
    PSEL_MOVE,
    PSEL_WHEEL,
    PSEL_BTN
  } psel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_MOVE,
    ST_PUSH_WHEEL,
    ST_PUSH_BTN,
    ST_POP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic  capture;
    logic  accum;
    logic  push;
    psel_e push_sel;
    logic  clr_xy;
    logic  clr_wheel;
    logic  btn_done;
    logic  pop;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       has_edge;
    logic       move_pending;
    logic       wheel_pending;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/mecq_ctrl.sv =====
`default_nettype none
module mecq_ctrl
  import mecq_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts_i.mode)
          MODE_REPORT: state_d = sts_i.has_edge ? ST_PUSH_MOVE : ST_RESP;
          MODE_FLUSH:  state_d = ST_PUSH_MOVE;
          MODE_POP:    state_d = ST_POP;
          default:     state_d = ST_RESP;
        endcase
      end
      ST_PUSH_MOVE:  state_d = ST_PUSH_WHEEL;
      ST_PUSH_WHEEL: state_d = (sts_i.mode == MODE_REPORT) ? ST_PUSH_BTN : ST_RESP;
      ST_PUSH_BTN:   state_d = ST_RESP;
      ST_POP:        state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.accum = (sts_i.mode == MODE_REPORT) && !sts_i.has_edge;
      end
      ST_PUSH_MOVE: begin
        cmd_o.push     = sts_i.move_pending;
        cmd_o.push_sel = PSEL_MOVE;
        cmd_o.clr_xy   = 1'b1;
      end
      ST_PUSH_WHEEL: begin
        cmd_o.push      = sts_i.wheel_pending;
        cmd_o.push_sel  = PSEL_WHEEL;
        cmd_o.clr_wheel = 1'b1;
      end
      ST_PUSH_BTN: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PSEL_BTN;
        cmd_o.btn_done = 1'b1;
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
      end
      ST_RESP: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // hold the result until the sink takes the beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/mecq_datapath.sv =====
`default_nettype none
module mecq_datapath
  import mecq_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [S_TDATA_W-1:0]  in_data_i,
  input  wire [S_TUSER_W-1:0]  in_user_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [M_TDATA_W-1:0] out_data_o,
  output logic [M_TUSER_W-1:0] out_user_o
);

  // captured item
  logic [1:0]        mode_q;
  logic [7:0]        buttons_q;
  logic signed [7:0] dx_q, dy_q, wh_q;

  logic [7:0]         prev_q;
  logic signed [31:0] px_q, py_q, pw_q;

  entry_t         queue_q [QUEUE_DEPTH];
  entry_t         queue_d [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic           refused_q;

  logic   ev_valid_q;
  entry_t ev_q;

  logic [M_TDATA_W-1:0] out_data_q;
  logic [M_TUSER_W-1:0] out_user_q;

  logic [7:0] pressed, released;
  entry_t     new_entry;
  logic       full, pop_fire;
  logic             plain_hit, move_hit, victim_found;
  logic [IDX_W-1:0] plain_idx, move_idx, victim;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v < -32'sd32768) r = -16'sd32768;
    else if (v > 32'sd32767) r = 16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [2:0] edge_button(input logic [7:0] mask);
    logic [2:0] r;
    if (mask[0]) r = BTN_LEFT;
    else if (mask[1]) r = BTN_RIGHT;
    else if (mask[2]) r = BTN_MIDDLE;
    else r = BTN_NONE;
    return r;
  endfunction

  assign pressed  = buttons_q & ~prev_q;
  assign released = prev_q & ~buttons_q;

  assign sts_o.mode          = mode_q;
  assign sts_o.has_edge      = (buttons_q != prev_q);
  assign sts_o.move_pending  = (px_q != 32'sd0) || (py_q != 32'sd0);
  assign sts_o.wheel_pending = (pw_q != 32'sd0);

  always_comb begin
    new_entry = '0;
    case (cmd_i.push_sel)
      PSEL_MOVE: begin
        new_entry.kind   = KIND_MOVE;
        new_entry.button = BTN_NONE;
        new_entry.x      = sat16(px_q);
        new_entry.y      = sat16(py_q);
      end
      PSEL_WHEEL: begin
        new_entry.kind   = KIND_MOVE;
        new_entry.button = pw_q[31] ? BTN_SCROLL_DOWN : BTN_SCROLL_UP;
      end
      PSEL_BTN: begin
        new_entry.kind   = (pressed != 8'd0) ? KIND_DOWN : KIND_UP;
        new_entry.button = edge_button((pressed != 8'd0) ? pressed : released);
        new_entry.x      = {{8{dx_q[7]}}, dx_q};
        new_entry.y      = {{8{dy_q[7]}}, dy_q};
      end
      default: new_entry = '0;
    endcase
  end

  // oldest plain move first, then oldest scroll event
  always_comb begin
    plain_hit = 1'b0;
    move_hit  = 1'b0;
    plain_idx = '0;
    move_idx  = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (queue_q[i].kind == KIND_MOVE) begin
        move_hit = 1'b1;
        move_idx = IDX_W'(i);
        if (queue_q[i].button == BTN_NONE) begin
          plain_hit = 1'b1;
          plain_idx = IDX_W'(i);
        end
      end
    end
    victim_found = plain_hit || move_hit;
    victim       = plain_hit ? plain_idx : move_idx;
  end

  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign pop_fire = cmd_i.pop && (count_q != '0);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) queue_d[i] = queue_q[i];
    count_d = count_q;
    if (pop_fire) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) queue_d[i] = queue_q[i + 1];
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.push) begin
      if (!full) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (CNT_W'(i) == count_q) queue_d[i] = new_entry;
        end
        count_d = count_q + CNT_W'(1);
      end else if (victim_found) begin
        // close the gap at the victim and append at the tail
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (IDX_W'(i) >= victim) queue_d[i] = queue_q[i + 1];
        end
        queue_d[QUEUE_DEPTH - 1] = new_entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) queue_q[i] <= queue_d[i];
    if (cmd_i.capture) begin
      mode_q    <= in_user_i;
      buttons_q <= in_data_i[7:0];
      dx_q      <= in_data_i[15:8];
      dy_q      <= in_data_i[23:16];
      wh_q      <= in_data_i[31:24];
      ev_q      <= '0;
    end else if (pop_fire) begin
      ev_q <= queue_q[0];
    end
    if (cmd_i.load_out) begin
      out_data_q <= {refused_q, QCOUNT_W'(count_q), ev_q.y, ev_q.x, ev_q.button};
      out_user_q <= {ev_q.kind, ev_valid_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      px_q       <= '0;
      py_q       <= '0;
      pw_q       <= '0;
      count_q    <= '0;
      refused_q  <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.capture) begin
        refused_q  <= 1'b0;
        ev_valid_q <= 1'b0;
      end else begin
        if (cmd_i.push && full && !victim_found) refused_q <= 1'b1;
        if (pop_fire) ev_valid_q <= 1'b1;
      end
      if (cmd_i.accum) begin
        prev_q <= buttons_q;
        px_q   <= px_q + {{24{dx_q[7]}}, dx_q};
        py_q   <= py_q + {{24{dy_q[7]}}, dy_q};
        pw_q   <= pw_q + {{24{wh_q[7]}}, wh_q};
      end
      if (cmd_i.clr_xy) begin
        px_q <= '0;
        py_q <= '0;
      end
      if (cmd_i.clr_wheel) pw_q <= '0;
      if (cmd_i.btn_done) begin
        // wheel was cleared by the flush, so it now holds only this report
        prev_q <= buttons_q;
        pw_q   <= {{24{wh_q[7]}}, wh_q};
      end
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule
`default_nettype wire

// ===== hdl/mouse_event_coalescing_queue_unit.sv =====
// channel  dir  tdata (low bit up)                            tuser (low bit up)
// s_axis   in   buttons[7:0] delta_x[15:8] delta_y[23:16]      mode[1:0]
//                wheel_step[31:24]
// m_axis   out  event_button[2:0] event_x[18:3] event_y[34:19] event_valid[0]
//                queue_count[38:35] refused[39]                 event_kind[2:1]
//
// One item at a time: idle, decode and response for a plain report or an unused
// mode, plus a pop for a read; a flush tick pushes the pending move and then the
// wheel, and a report with a button edge also the button event, at most one
// event per cycle into the queue. Result valid rises as the unit is ready again.
// Reset clears the queue count, button history and pending motion; no sweep.
// A stalled result holds in the output register; a finished item waits behind it.
`default_nettype none
module mouse_event_coalescing_queue_unit
  import mecq_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [S_TDATA_W-1:0]  s_axis_tdata,  // buttons, delta_x, delta_y, wheel_step
  input  wire [S_TUSER_W-1:0]  s_axis_tuser,  // mode
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // button, x, y, queue_count, refused
  output logic [M_TUSER_W-1:0] m_axis_tuser   // event_valid, event_kind
);

  cmd_t cmd;
  sts_t sts;

  mecq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mecq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule
`default_nettype wire
